[rtl/hss_pkg.sv]
`timescale 1ns / 1ps
package hss_pkg;

	localparam int unsigned HW      = 16;  // height width
	localparam int unsigned GW      = 24;  // gain width
	localparam int unsigned SW      = 19;  // signed Sobel sum width
	localparam int unsigned MW      = 42;  // |sum| * gain width
	localparam int unsigned NW      = 15;  // normal magnitude width
	localparam logic [GW-1:0] GAIN_RESET = GW'(8192);
	localparam logic [NW-1:0] ONE_Q14    = NW'(16384);

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	typedef struct packed {
		logic                 opcode;
		logic [5:0]           col;
		logic [5:0]           row;
		logic signed [HW-1:0] height;
	} in_item_t;

	typedef struct packed {
		logic                 is_compute;
		logic signed [15:0]   normal_x;
		logic [14:0]          normal_y;
		logic signed [15:0]   normal_z;
		logic [14:0]          slope;
	} out_item_t;

	typedef struct packed {
		logic [MW-1:0] ma;
		logic [MW-1:0] mb;
	} norm_req_t;

	typedef struct packed {
		logic [NW-1:0] nx;
		logic [NW-1:0] ny;
		logic [NW-1:0] nz;
	} norm_rsp_t;

	// neighbor order: (-1,-1) (0,-1) (1,-1) (-1,0) (1,0) (-1,1) (0,1) (1,1)
	function automatic logic [1:0] nbr_dx(input logic [2:0] k);
		logic [1:0] d;
		unique case (k)
			3'd0, 3'd3, 3'd5: d = 2'd0;   // left
			3'd1, 3'd6:       d = 2'd1;   // center
			default:          d = 2'd2;   // right
		endcase
		return d;
	endfunction

	function automatic logic [1:0] nbr_dz(input logic [2:0] k);
		logic [1:0] d;
		unique case (k)
			3'd0, 3'd1, 3'd2: d = 2'd0;   // top
			3'd3, 3'd4:       d = 2'd1;   // center
			default:          d = 2'd2;   // bottom
		endcase
		return d;
	endfunction

	function automatic logic signed [2:0] nbr_wx(input logic [2:0] k);
		logic signed [2:0] w;
		unique case (k)
			3'd0, 3'd5: w = 3'sd1;
			3'd3:       w = 3'sd2;
			3'd2, 3'd7: w = -3'sd1;
			3'd4:       w = -3'sd2;
			default:    w = 3'sd0;
		endcase
		return w;
	endfunction

	function automatic logic signed [2:0] nbr_wz(input logic [2:0] k);
		logic signed [2:0] w;
		unique case (k)
			3'd0, 3'd2: w = 3'sd1;
			3'd1:       w = 3'sd2;
			3'd5, 3'd7: w = -3'sd1;
			3'd6:       w = -3'sd2;
			default:    w = 3'sd0;
		endcase
		return w;
	endfunction

	function automatic logic signed [SW-1:0] weigh(input logic signed [HW-1:0] h,
			input logic signed [2:0] w);
		logic signed [SW-1:0] e;
		logic signed [SW-1:0] r;
		e = SW'(h);
		unique case (w)
			3'sd1:   r = e;
			3'sd2:   r = e <<< 1;
			-3'sd1:  r = -e;
			-3'sd2:  r = -(e <<< 1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/hss_ram.sv]
`timescale 1ns / 1ps
module hss_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/hss_norm.sv]
`timescale 1ns / 1ps
module hss_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hss_pkg::norm_req_t req,
	output logic              done,
	output hss_pkg::norm_rsp_t rsp
);
	import hss_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_SQ    = 3'd2;
	localparam logic [2:0] ST_SQRT  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;

	logic [2:0]    state_q;
	logic [4:0]    cnt_q;
	logic [MW-1:0] ma_q, mb_q;
	logic [16:0]   mc_q;
	logic [59:0]   sq_q;
	logic [61:0]   v_q, res_q, bit_q;
	logic [31:0]   rx_q, ry_q, rz_q;
	logic [15:0]   qx_q, qy_q, qz_q;
	logic          done_q;
	norm_rsp_t     rsp_q;

	logic [29:0] sq_sel;
	logic [61:0] trial;
	logic [30:0] len;
	logic [31:0] tx, ty, tz;
	logic        gx, gy, gz;
	logic [16:0] sx1, sy1, sz1;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    sq_sel = ma_q[29:0];
			2'd1:    sq_sel = mb_q[29:0];
			default: sq_sel = {13'd0, mc_q};
		endcase
		trial = res_q + bit_q;
		len   = res_q[30:0];
		// first step compares the magnitude itself, later ones the doubled remainder
		tx = (cnt_q == 5'd0) ? rx_q : {rx_q[30:0], 1'b0};
		ty = (cnt_q == 5'd0) ? ry_q : {ry_q[30:0], 1'b0};
		tz = (cnt_q == 5'd0) ? rz_q : {rz_q[30:0], 1'b0};
		gx = tx >= {1'b0, len};
		gy = ty >= {1'b0, len};
		gz = tz >= {1'b0, len};
		sx1 = {1'b0, qx_q[14:0], gx} + 17'd1;
		sy1 = {1'b0, qy_q[14:0], gy} + 17'd1;
		sz1 = {1'b0, qz_q[14:0], gz} + 17'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (!(|ma_q[MW-1:30]) && !(|mb_q[MW-1:30])) begin
						state_q <= ST_SQ;
						cnt_q   <= '0;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd3) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (bit_q[0]) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ma_q <= req.ma;
				mb_q <= req.mb;
				mc_q <= 17'd65536;
			end
			ST_SHIFT: begin
				if ((|ma_q[MW-1:30]) || (|mb_q[MW-1:30])) begin
					ma_q <= ma_q >> 1;
					mb_q <= mb_q >> 1;
					mc_q <= mc_q >> 1;
				end
				v_q <= '0;
			end
			ST_SQ: begin
				sq_q <= 60'(sq_sel) * 60'(sq_sel);
				if (cnt_q != 5'd0) begin
					v_q <= v_q + {2'b0, sq_q};
				end
				res_q <= '0;
				bit_q <= 62'd1 << 60;
			end
			ST_SQRT: begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				rx_q  <= {2'b0, ma_q[29:0]};
				ry_q  <= {15'd0, mc_q};
				rz_q  <= {2'b0, mb_q[29:0]};
			end
			ST_DIV: begin
				if (gx) rx_q <= tx - {1'b0, len}; else rx_q <= tx;
				if (gy) ry_q <= ty - {1'b0, len}; else ry_q <= ty;
				if (gz) rz_q <= tz - {1'b0, len}; else rz_q <= tz;
				qx_q <= {qx_q[14:0], gx};
				qy_q <= {qy_q[14:0], gy};
				qz_q <= {qz_q[14:0], gz};
				if (cnt_q == 5'd15) begin
					rsp_q.nx <= sx1[15:1];
					rsp_q.ny <= sy1[15:1];
					rsp_q.nz <= sz1[15:1];
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;
endmodule

[rtl/heightmap_sobel_normal_slope_top.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Beat when               | Payload
// in       | input     | in_valid && !in_stall   | in_data  (opcode, col, row, height)
// out      | output    | out_valid && !out_stall | out_data (is_compute, normal, slope)
// cfg      | input     | cfg_valid && cfg_ready  | cfg_data (sobel_gain, 24 bit)
//
// After reset a clearing pass zeroes all GRID_DIM*GRID_DIM entries of the height memory
// (4096 at the default) with in_stall high; cfg beats are taken throughout.
// A write item goes straight to the result step; a compute item runs the neighbor reads,
// the gain multiply, the handoff, the normalizing shifts, the squares, the square root
// steps and the divider steps, then sees done, loads the result and accepts.
// A held result lets the next item in; that item then waits until the result is taken.
module heightmap_sobel_normal_slope_top #(
	parameter int unsigned GRID_DIM = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  hss_pkg::in_item_t     in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output hss_pkg::out_item_t    out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [23:0]           cfg_data
);
	import hss_pkg::*;

	localparam int unsigned DEPTH = GRID_DIM * GRID_DIM;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(GRID_DIM);
	localparam int unsigned XW    = (CW > 6) ? CW + 1 : 7;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_NORM  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]           state_q;
	logic [AW-1:0]        clr_q;
	logic [GW-1:0]        gain_q;
	logic                 is_comp_q;
	logic [CW-1:0]        xc_q, zc_q;
	logic [3:0]           rd_q;
	logic signed [SW-1:0] sx_q, sz_q;
	logic                 negx_q, negz_q;
	norm_req_t            req_q;
	logic                 start_q;
	out_item_t            out_q;
	logic                 out_valid_q;

	logic                 in_beat, out_free;
	logic [XW-1:0]        col_x, row_x;
	logic [CW-1:0]        xn, zn;
	logic [2:0]           k_rd, k_acc;
	logic                 we;
	logic [AW-1:0]        waddr, raddr;
	logic [HW-1:0]        wdata, rdata;
	logic [17:0]          absx, absz;
	logic                 norm_done;
	norm_rsp_t            rsp;

	assign in_beat   = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign col_x = XW'(in_data.col);
	assign row_x = XW'(in_data.row);

	// neighbor coordinates, clamped at the borders so edge cells repeat
	assign k_rd  = rd_q[2:0];
	assign k_acc = 3'(rd_q - 4'd1);
	always_comb begin
		unique case (nbr_dx(k_rd))
			2'd0:    xn = (xc_q == '0) ? xc_q : xc_q - CW'(1);
			2'd1:    xn = xc_q;
			default: xn = (xc_q == CW'(GRID_DIM - 1)) ? xc_q : xc_q + CW'(1);
		endcase
		unique case (nbr_dz(k_rd))
			2'd0:    zn = (zc_q == '0) ? zc_q : zc_q - CW'(1);
			2'd1:    zn = zc_q;
			default: zn = (zc_q == CW'(GRID_DIM - 1)) ? zc_q : zc_q + CW'(1);
		endcase
	end
	assign raddr = AW'(zn) * AW'(GRID_DIM) + AW'(xn);

	// one write port: clearing sweep during ST_CLEAR, else write beats
	always_comb begin
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = in_beat && (in_data.opcode == OP_WRITE)
				&& (col_x < XW'(GRID_DIM)) && (row_x < XW'(GRID_DIM));
			waddr = AW'(in_data.row) * AW'(GRID_DIM) + AW'(in_data.col);
			wdata = in_data.height;
		end
	end

	hss_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign absx = sx_q[SW-1] ? 18'(-sx_q) : sx_q[17:0];
	assign absz = sz_q[SW-1] ? 18'(-sz_q) : sz_q[17:0];

	hss_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.req    (req_q),
		.done   (norm_done),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			gain_q      <= GAIN_RESET;
			rd_q        <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				gain_q <= cfg_data;
			end
			// load a new result when free, else drop the taken one
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_beat) begin
						rd_q    <= '0;
						state_q <= (in_data.opcode == OP_COMPUTE) ? ST_READ : ST_DONE;
					end
				end
				ST_READ: begin
					rd_q <= rd_q + 4'd1;
					if (rd_q == 4'd8) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					start_q <= 1'b1;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (norm_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the result register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			is_comp_q <= in_data.opcode;
			xc_q <= (col_x >= XW'(GRID_DIM)) ? CW'(GRID_DIM - 1) : CW'(col_x);
			zc_q <= (row_x >= XW'(GRID_DIM)) ? CW'(GRID_DIM - 1) : CW'(row_x);
			sx_q <= '0;
			sz_q <= '0;
		end
		if (state_q == ST_READ && rd_q != 4'd0) begin
			sx_q <= sx_q + weigh(rdata, nbr_wx(k_acc));
			sz_q <= sz_q + weigh(rdata, nbr_wz(k_acc));
		end
		if (state_q == ST_MUL) begin
			req_q.ma <= MW'(absx) * MW'(gain_q);
			req_q.mb <= MW'(absz) * MW'(gain_q);
			negx_q   <= sx_q[SW-1];
			negz_q   <= sz_q[SW-1];
		end
		if (state_q == ST_DONE && out_free) begin
			if (is_comp_q) begin
				out_q.is_compute <= 1'b1;
				out_q.normal_x   <= negx_q ? -{1'b0, rsp.nx} : {1'b0, rsp.nx};
				out_q.normal_y   <= rsp.ny;
				out_q.normal_z   <= negz_q ? -{1'b0, rsp.nz} : {1'b0, rsp.nz};
				out_q.slope      <= ONE_Q14 - rsp.ny;
			end else begin
				out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
